FILE: hdl/arm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_pkg
// Shared constants, types and helpers of the AC RMS current meter.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int ADC_BITS       = 12;
  localparam int PRIME_LOG2     = 5;
  localparam int PRIME_SAMPLES  = 1 << PRIME_LOG2;
  localparam int WARMUP_SAMPLES = 200;
  localparam int GAIN_FRAC      = 24;
  localparam int BASE_TO_Q8     = 16;
  localparam int CAL_SHIFT      = 12;

  localparam int SAMPLE_W = 12;
  localparam int WL_W     = 10;
  localparam int GAIN_W   = 16;
  localparam int CAL_W    = 20;
  localparam int GATE_W   = 32;
  localparam int CUR_W    = 32;
  localparam int Q8_W     = ADC_BITS + 8;
  localparam int BASE_W   = ADC_BITS + GAIN_FRAC;
  localparam int PSUM_W   = ADC_BITS + PRIME_LOG2;
  localparam int SQS_W    = 50;
  localparam int MEAN_W   = 2 * Q8_W;
  localparam int CNT_W    = 10;
  localparam int CFG_W    = 32;
  localparam int QDEPTH   = 2;

  localparam logic [WL_W-1:0]   WINDOW_LENGTH_RST  = WL_W'(600);
  localparam logic [GAIN_W-1:0] BASELINE_GAIN_RST  = GAIN_W'(537);
  localparam logic [CAL_W-1:0]  AMPS_PER_COUNT_RST = CAL_W'(7435);
  localparam logic [GATE_W-1:0] NOISE_GATE_RST     = GATE_W'(13107);

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH  = 2'd0,
    REG_BASELINE_GAIN  = 2'd1,
    REG_AMPS_PER_COUNT = 2'd2,
    REG_NOISE_GATE     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [WL_W-1:0]   window_length;
    logic [GAIN_W-1:0] baseline_gain;
    logic [CAL_W-1:0]  amps_per_count;
    logic [GATE_W-1:0] noise_gate;
  } cfg_t;

  typedef enum logic [2:0] {
    OP_PRIME      = 3'd0,
    OP_PRIME_LAST = 3'd1,
    OP_WARM       = 3'd2,
    OP_RUN        = 3'd3,
    OP_RUN_LAST   = 3'd4
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [ADC_BITS-1:0] x;
  } qent_t;

  // a zero window length acts as one
  function automatic logic [WL_W:0] eff_window(input logic [WL_W-1:0] wl);
    eff_window = (wl == '0) ? (WL_W+1)'(1) : {1'b0, wl};
  endfunction

endpackage
`default_nettype wire

FILE: hdl/arm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_if
// Valid/ready channels for samples and results of the meter.
// ----------------------------------------------------------------------------
interface arm_sample_if;
  logic                          valid;
  logic                          ready;
  logic [arm_pkg::SAMPLE_W-1:0]  sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface arm_result_if;
  logic                       valid;
  logic                       ready;
  logic [arm_pkg::CUR_W-1:0]  current;
  logic [arm_pkg::Q8_W-1:0]   rms_counts;
  logic [arm_pkg::Q8_W-1:0]   baseline_now;
  modport source (output valid, output current, output rms_counts, output baseline_now,
                  input ready);
  modport sink   (input valid, input current, input rms_counts, input baseline_now,
                  output ready);
endinterface
`default_nettype wire

FILE: hdl/arm_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_front
// Accept samples, track the phase and count, tag each item with its operation.
// ----------------------------------------------------------------------------
module arm_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  arm_sample_if.sink                     samples,
  input  wire logic [arm_pkg::WL_W-1:0]  window_length,
  input  wire logic                      full,
  output logic                           push,
  output arm_pkg::qent_t                 push_data
);

  typedef enum logic [2:0] {
    PH_PRIMING = 3'b001,
    PH_WARMUP  = 3'b010,
    PH_RUNNING = 3'b100
  } phase_t;

  phase_t                       phase, phase_next;
  logic [arm_pkg::CNT_W-1:0]    count;
  logic [arm_pkg::CNT_W:0]      cnt_inc;
  logic [arm_pkg::WL_W:0]       wl_eff;
  logic                         last;
  arm_pkg::op_t                 op;

  assign samples.ready = !full;
  assign push          = samples.valid && !full;
  assign cnt_inc       = {1'b0, count} + (arm_pkg::CNT_W+1)'(1);
  assign wl_eff        = arm_pkg::eff_window(window_length);

  always_comb begin
    last       = 1'b0;
    op         = arm_pkg::OP_PRIME;
    phase_next = phase;
    unique case (phase)
      PH_WARMUP: begin
        last = cnt_inc >= (arm_pkg::CNT_W+1)'(arm_pkg::WARMUP_SAMPLES);
        op   = arm_pkg::OP_WARM;
        if (last) phase_next = PH_RUNNING;
      end
      PH_RUNNING: begin
        last = cnt_inc >= (arm_pkg::CNT_W+1)'(wl_eff);
        op   = last ? arm_pkg::OP_RUN_LAST : arm_pkg::OP_RUN;
      end
      default: begin
        last = cnt_inc >= (arm_pkg::CNT_W+1)'(arm_pkg::PRIME_SAMPLES);
        op   = last ? arm_pkg::OP_PRIME_LAST : arm_pkg::OP_PRIME;
        phase_next = PH_PRIMING;
        if (last) phase_next = (arm_pkg::WARMUP_SAMPLES > 0) ? PH_WARMUP : PH_RUNNING;
      end
    endcase
  end

  assign push_data.op = op;
  assign push_data.x  = samples.sample[arm_pkg::ADC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PRIMING;
      count <= '0;
    end else if (push) begin
      phase <= phase_next;
      count <= last ? '0 : cnt_inc[arm_pkg::CNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/arm_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_queue
// Short FIFO of tagged items between the front and the back.
// ----------------------------------------------------------------------------
module arm_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire arm_pkg::qent_t  push_data,
  output logic                 full,
  input  wire logic            pop,
  output logic                 not_empty,
  output arm_pkg::qent_t       pop_data
);

  localparam int PTR_W = $clog2(arm_pkg::QDEPTH);
  localparam int FILL_W = $clog2(arm_pkg::QDEPTH + 1);

  arm_pkg::qent_t     mem [arm_pkg::QDEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [FILL_W-1:0]  fill;

  assign full      = fill == FILL_W'(arm_pkg::QDEPTH);
  assign not_empty = fill != '0;
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(arm_pkg::QDEPTH-1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(arm_pkg::QDEPTH-1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      fill <= fill + FILL_W'(1);
      else if (pop && !push) fill <= fill - FILL_W'(1);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/arm_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arm_back
// Baseline tracker, square accumulator, divider, square root and scaling.
// ----------------------------------------------------------------------------
module arm_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire arm_pkg::cfg_t   cfg,
  input  wire logic            op_valid,
  input  wire arm_pkg::qent_t  op_data,
  output logic                 pop,
  arm_result_if.source         results
);

  localparam int PROD_W = arm_pkg::GAIN_W + arm_pkg::BASE_W;
  localparam int STEP_W = PROD_W - arm_pkg::GAIN_FRAC;
  localparam int ITER_W = $clog2(arm_pkg::SQS_W);
  localparam int SREM_W = arm_pkg::Q8_W + 1;
  localparam int SCL_W  = arm_pkg::Q8_W + arm_pkg::CAL_W;
  localparam int SCD_W  = SCL_W - arm_pkg::CAL_SHIFT;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_MUL   = 8'b0000_0010,
    ST_UPD   = 8'b0000_0100,
    ST_SQ    = 8'b0000_1000,
    ST_DIV   = 8'b0001_0000,
    ST_SQRT  = 8'b0010_0000,
    ST_SCALE = 8'b0100_0000,
    ST_FIN   = 8'b1000_0000
  } state_t;

  state_t                          state;
  logic [arm_pkg::ADC_BITS-1:0]    x_q;
  logic                            last_q, run_q, neg_q;
  logic [arm_pkg::BASE_W-1:0]      dif, baseline, target;
  logic [PROD_W-1:0]               prod;
  logic [arm_pkg::PSUM_W-1:0]      prime_sum, psum_new;
  logic [arm_pkg::SQS_W-1:0]       sq_sum, sq_sum_new, dq, dq_next;
  logic [arm_pkg::WL_W-1:0]        rem_d;
  logic [arm_pkg::WL_W:0]          trial, wl_eff;
  logic                            div_ge;
  logic [ITER_W-1:0]               iter;
  logic [arm_pkg::MEAN_W-1:0]      sq_val;
  logic [SREM_W-1:0]               sq_rem;
  logic [SREM_W+1:0]               r_sh, t_sq, r_diff;
  logic [arm_pkg::Q8_W-1:0]        root, xs, b8, mag;
  logic [SCL_W-1:0]                scl;
  logic [SCD_W-1:0]                scaled;
  logic [arm_pkg::CUR_W-1:0]       cur, gated;
  logic [STEP_W-1:0]               step;
  logic                            load;

  assign pop      = (state == ST_IDLE) && op_valid;
  assign target   = arm_pkg::BASE_W'(op_data.x) << arm_pkg::GAIN_FRAC;
  assign psum_new = prime_sum + arm_pkg::PSUM_W'(op_data.x);

  // round the downward step away from zero so the baseline never undershoots
  assign step = prod[PROD_W-1:arm_pkg::GAIN_FRAC]
              + STEP_W'(neg_q && (prod[arm_pkg::GAIN_FRAC-1:0] != '0));

  assign xs         = {x_q, 8'b0};
  assign b8         = baseline[arm_pkg::BASE_W-1:arm_pkg::BASE_TO_Q8];
  assign mag        = (xs >= b8) ? xs - b8 : b8 - xs;
  assign sq_sum_new = sq_sum + arm_pkg::SQS_W'(mag) * arm_pkg::SQS_W'(mag);

  assign wl_eff  = arm_pkg::eff_window(cfg.window_length);
  assign trial   = {rem_d, dq[arm_pkg::SQS_W-1]};
  assign div_ge  = trial >= wl_eff;
  assign dq_next = {dq[arm_pkg::SQS_W-2:0], div_ge};

  assign r_sh   = {sq_rem, sq_val[arm_pkg::MEAN_W-1 -: 2]};
  assign t_sq   = {1'b0, root, 2'b01};
  assign r_diff = r_sh - t_sq;

  // the scaled value is below 2^28 and cannot reach the 32-bit limit
  assign scaled = scl[SCL_W-1:arm_pkg::CAL_SHIFT];
  assign cur    = arm_pkg::CUR_W'(scaled);
  assign gated  = (cur < cfg.noise_gate) ? '0 : cur;
  assign load   = (state == ST_FIN) && (!results.valid || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      prime_sum <= '0;
      baseline  <= '0;
      sq_sum    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            x_q    <= op_data.x;
            last_q <= op_data.op == arm_pkg::OP_RUN_LAST;
            run_q  <= op_data.op != arm_pkg::OP_WARM;
            neg_q  <= target < baseline;
            dif    <= (target < baseline) ? baseline - target : target - baseline;
            case (op_data.op)
              arm_pkg::OP_PRIME: prime_sum <= psum_new;
              arm_pkg::OP_PRIME_LAST: begin
                baseline  <= arm_pkg::BASE_W'(psum_new)
                             << (arm_pkg::GAIN_FRAC - arm_pkg::PRIME_LOG2);
                prime_sum <= '0;
              end
              default: state <= ST_MUL;
            endcase
          end
        end
        ST_MUL: begin
          prod  <= cfg.baseline_gain * dif;
          state <= ST_UPD;
        end
        ST_UPD: begin
          baseline <= neg_q ? baseline - arm_pkg::BASE_W'(step)
                            : baseline + arm_pkg::BASE_W'(step);
          state    <= run_q ? ST_SQ : ST_IDLE;
        end
        ST_SQ: begin
          if (last_q) begin
            dq     <= sq_sum_new;
            sq_sum <= '0;
            rem_d  <= '0;
            iter   <= '0;
            state  <= ST_DIV;
          end else begin
            sq_sum <= sq_sum_new;
            state  <= ST_IDLE;
          end
        end
        ST_DIV: begin
          rem_d <= div_ge ? arm_pkg::WL_W'(trial - wl_eff) : trial[arm_pkg::WL_W-1:0];
          dq    <= dq_next;
          if (iter == ITER_W'(arm_pkg::SQS_W-1)) begin
            sq_val <= dq_next[arm_pkg::MEAN_W-1:0];
            sq_rem <= '0;
            root   <= '0;
            iter   <= '0;
            state  <= ST_SQRT;
          end else begin
            iter <= iter + ITER_W'(1);
          end
        end
        ST_SQRT: begin
          sq_val <= {sq_val[arm_pkg::MEAN_W-3:0], 2'b00};
          if (!r_diff[SREM_W+1]) begin
            sq_rem <= r_diff[SREM_W-1:0];
            root   <= {root[arm_pkg::Q8_W-2:0], 1'b1};
          end else begin
            sq_rem <= r_sh[SREM_W-1:0];
            root   <= {root[arm_pkg::Q8_W-2:0], 1'b0};
          end
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(arm_pkg::Q8_W-1)) state <= ST_SCALE;
        end
        ST_SCALE: begin
          scl   <= root * cfg.amps_per_count;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      results.current      <= gated;
      results.rms_counts   <= root;
      results.baseline_now <= b8;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == ST_IDLE) else $error("item taken outside idle");
  a_close_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQ && last_q) |=> state == ST_DIV) else $error("window close lost");
  a_load_fin: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !$past(results.valid)) |-> $past(state) == ST_FIN)
    else $error("result raised outside finish");

endmodule
`default_nettype wire

FILE: hdl/ac_rms_current_meter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ac_rms_current_meter_unit
// True-RMS current meter with DC baseline tracking for CT ADC samples.
// ----------------------------------------------------------------------------
// The first 32 samples after reset seed the DC baseline, the next 200 only
// run the tracker, and from then on every window of window_length samples
// yields one result: RMS of the AC part (counts, 8 fraction bits), baseline
// at window end, and the calibrated current gated by noise_gate. A priming
// sample needs only the idle step of the back end; warm-up adds the tracker
// multiply and baseline update steps, and running adds the square-accumulate
// step. A window close adds the bit-serial divide, the square root, a scale
// step and the load of the output register, which waits while a held result
// is not yet taken; a two-item queue lets samples keep arriving meanwhile.
// Write configuration only while idle; index 0 window_length, 1
// baseline_gain, 2 amps_per_count, 3 noise_gate.
// ----------------------------------------------------------------------------
module ac_rms_current_meter_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  arm_sample_if.sink                      samples,
  arm_result_if.source                    results,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [arm_pkg::CFG_W-1:0]  cfg_wdata
);

  arm_pkg::cfg_t   cfg;
  arm_pkg::qent_t  push_data, pop_data;
  logic            push, pop, full, not_empty;

  // hold configuration; truncate write data to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_length  <= arm_pkg::WINDOW_LENGTH_RST;
      cfg.baseline_gain  <= arm_pkg::BASELINE_GAIN_RST;
      cfg.amps_per_count <= arm_pkg::AMPS_PER_COUNT_RST;
      cfg.noise_gate     <= arm_pkg::NOISE_GATE_RST;
    end else if (cfg_we) begin
      unique case (arm_pkg::reg_index_t'(cfg_index))
        arm_pkg::REG_WINDOW_LENGTH:  cfg.window_length  <= cfg_wdata[arm_pkg::WL_W-1:0];
        arm_pkg::REG_BASELINE_GAIN:  cfg.baseline_gain  <= cfg_wdata[arm_pkg::GAIN_W-1:0];
        arm_pkg::REG_AMPS_PER_COUNT: cfg.amps_per_count <= cfg_wdata[arm_pkg::CAL_W-1:0];
        arm_pkg::REG_NOISE_GATE:     cfg.noise_gate     <= cfg_wdata[arm_pkg::GATE_W-1:0];
        default: ;
      endcase
    end
  end

  // classify each sample by phase and window position
  arm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .samples       (samples),
    .window_length (cfg.window_length),
    .full          (full),
    .push          (push),
    .push_data     (push_data)
  );

  // decouple the front from the long window-close work
  arm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_data  (pop_data)
  );

  // tracker, accumulator and result arithmetic
  arm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op_valid (not_empty),
    .op_data  (pop_data),
    .pop      (pop),
    .results  (results)
  );

endmodule
`default_nettype wire

FILE: test/tb_arm_if.sv
// ----------------------------------------------------------------------------
// tb_arm_if
// Passive probe of the meter channels; the checker samples it at the rising clock edge.
// ----------------------------------------------------------------------------
interface tb_arm_probe (input logic clk);
  logic        s_fire;
  logic [11:0] s_sample;
  logic        r_fire;
  logic [31:0] r_current;
  logic [19:0] r_rms;
  logic [19:0] r_base;
endinterface

FILE: test/arm_meter_checker.sv
// ----------------------------------------------------------------------------
// arm_meter_checker
// Predicts meter results from accepted samples and compares them in order.
// ----------------------------------------------------------------------------
module arm_meter_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_fire,
  input  logic [11:0] s_sample,
  input  logic        r_fire,
  input  logic [31:0] r_current,
  input  logic [19:0] r_rms,
  input  logic [19:0] r_base,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);
  typedef enum logic [1:0] {PH_PRIME, PH_WARM, PH_RUN} meter_phase_t;
  typedef struct packed {
    logic [31:0] current;
    logic [19:0] rms;
    logic [19:0] base;
  } reading_t;

  arm_pkg::cfg_t cfg;
  meter_phase_t  ph;
  int unsigned   cnt;
  logic [63:0]   psum, base_acc, sq_acc;
  reading_t      readings_due[$];

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  task automatic follow(input logic [63:0] x);
    logic [63:0] tgt, d, p;
    tgt = x << arm_pkg::GAIN_FRAC;
    if (tgt >= base_acc) begin
      d = tgt - base_acc;
      base_acc += ({48'd0, cfg.baseline_gain} * d) >> arm_pkg::GAIN_FRAC;
    end else begin
      d = base_acc - tgt;
      p = {48'd0, cfg.baseline_gain} * d;
      base_acc -= (p >> arm_pkg::GAIN_FRAC) + ((p[23:0] != 0) ? 64'd1 : 64'd0);
    end
  endtask

  task automatic take_sample(input logic [11:0] s);
    logic [63:0] x, b8, mag, wl, cur, rms;
    reading_t    rd;
    x = {52'd0, s};
    case (ph)
      PH_WARM: begin
        follow(x);
        cnt++;
        if (cnt >= arm_pkg::WARMUP_SAMPLES) begin
          ph = PH_RUN;
          cnt = 0;
        end
      end
      PH_RUN: begin
        wl = (cfg.window_length == 0) ? 64'd1 : {54'd0, cfg.window_length};
        follow(x);
        b8 = base_acc >> arm_pkg::BASE_TO_Q8;
        mag = ((x << 8) >= b8) ? (x << 8) - b8 : b8 - (x << 8);
        sq_acc += mag * mag;
        cnt++;
        if (cnt >= wl) begin
          rms = root_floor(sq_acc / wl);
          cur = (rms * {44'd0, cfg.amps_per_count}) >> arm_pkg::CAL_SHIFT;
          if (cur > 64'hFFFF_FFFF) cur = 64'hFFFF_FFFF;
          if (cur < {32'd0, cfg.noise_gate}) cur = 0;
          rd.current = cur[31:0];
          rd.rms = rms[19:0];
          rd.base = b8[19:0];
          readings_due.push_back(rd);
          sq_acc = 0;
          cnt = 0;
        end
      end
      default: begin
        psum += x;
        cnt++;
        if (cnt >= arm_pkg::PRIME_SAMPLES) begin
          base_acc = (psum << arm_pkg::GAIN_FRAC) / arm_pkg::PRIME_SAMPLES;
          psum = 0;
          cnt = 0;
          ph = (arm_pkg::WARMUP_SAMPLES > 0) ? PH_WARM : PH_RUN;
        end
      end
    endcase
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg = {arm_pkg::WINDOW_LENGTH_RST, arm_pkg::BASELINE_GAIN_RST,
             arm_pkg::AMPS_PER_COUNT_RST, arm_pkg::NOISE_GATE_RST};
      ph = PH_PRIME;
      cnt = 0;
      psum = 0;
      base_acc = 0;
      sq_acc = 0;
      readings_due.delete();
    end else begin
      if (cfg_we) begin
        case (arm_pkg::reg_index_t'(cfg_index))
          arm_pkg::REG_WINDOW_LENGTH:  cfg.window_length = cfg_wdata[9:0];
          arm_pkg::REG_BASELINE_GAIN:  cfg.baseline_gain = cfg_wdata[15:0];
          arm_pkg::REG_AMPS_PER_COUNT: cfg.amps_per_count = cfg_wdata[19:0];
          arm_pkg::REG_NOISE_GATE:     cfg.noise_gate = cfg_wdata;
          default: ;
        endcase
      end
      if (s_fire) take_sample(s_sample);
      if (r_fire) begin
        if (readings_due.size() == 0) begin
          report("unexpected result", r_current, 0);
        end else begin
          if (r_current !== readings_due[0].current)
            report("current", r_current, readings_due[0].current);
          if (r_rms !== readings_due[0].rms) report("rms_counts", r_rms, readings_due[0].rms);
          if (r_base !== readings_due[0].base)
            report("baseline_now", r_base, readings_due[0].base);
          void'(readings_due.pop_front());
        end
      end
    end
    pending = readings_due.size();
  end
endmodule

FILE: test/tb_ac_rms_current_meter_unit.sv
// ----------------------------------------------------------------------------
// tb_ac_rms_current_meter_unit
// Drives samples and register writes into the meter and gives the verdict;
// a side checker predicts each window reading and compares it.
// ----------------------------------------------------------------------------
module tb_ac_rms_current_meter_unit;

  localparam int WATCHDOG = 20000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;
  int          fails, pending;
  int          send_idle, recv_idle;  // idle chance in percent
  bit          hold_off;
  int          quiet;

  arm_sample_if samp_ch ();
  arm_result_if res_ch ();
  tb_arm_probe  probe (clk);

  ac_rms_current_meter_unit uut (
    .clk(clk), .rst(rst), .samples(samp_ch), .results(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  assign probe.s_fire    = samp_ch.valid && samp_ch.ready;
  assign probe.s_sample  = samp_ch.sample;
  assign probe.r_fire    = res_ch.valid && res_ch.ready;
  assign probe.r_current = res_ch.current;
  assign probe.r_rms     = res_ch.rms_counts;
  assign probe.r_base    = res_ch.baseline_now;

  arm_meter_checker chk (
    .clk(clk), .rst(rst),
    .s_fire(probe.s_fire), .s_sample(probe.s_sample),
    .r_fire(probe.r_fire), .r_current(probe.r_current),
    .r_rms(probe.r_rms), .r_base(probe.r_base),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: stall at random, or hold off for a long stretch on request.
  initial begin
    res_ch.ready = 0;
    forever begin
      @(negedge clk);
      res_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog: count cycles with nothing accepted.
  always @(posedge clk) begin
    if (rst || (samp_ch.valid && samp_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offer one sample, idling at random first; hold valid until accepted.
  // Valid stays high afterwards so back-to-back items need no gap.
  task automatic send_sample(input logic [11:0] s);
    while ($urandom_range(99) < send_idle) begin
      samp_ch.valid <= 0;
      @(negedge clk);
    end
    samp_ch.valid <= 1;
    samp_ch.sample <= s;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid, wait for every reading to drain, then let the back end settle.
  task automatic drain();
    samp_ch.valid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic write_reg(input arm_pkg::reg_index_t idx, input logic [31:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  // Sine-like test tone around a DC offset, with random noise.
  function automatic logic [11:0] tone(input int n, input int amp, input int dc);
    int v;
    v = dc + int'(amp * $sin(6.2832 * n / 37.0)) + int'($urandom_range(8)) - 4;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  task automatic phase_run(input int n_items, input int amp);
    int dc;
    dc = $urandom_range(4095);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(9) == 0) send_sample(12'($urandom_range(4095)));
      else send_sample(tone(i, amp, dc));
    end
  endtask

  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    samp_ch.valid = 0;
    samp_ch.sample = 0;
    send_idle = 11;
    recv_idle = 58;
    hold_off = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Short windows so the directed part yields readings soon.
    write_reg(arm_pkg::REG_WINDOW_LENGTH, 4);
    write_reg(arm_pkg::REG_NOISE_GATE, 0);

    // Priming with extremes, then warm-up.
    for (int i = 0; i < arm_pkg::PRIME_SAMPLES; i++) send_sample(i[0] ? 12'hFFF : 12'h000);
    for (int i = 0; i < arm_pkg::WARMUP_SAMPLES; i++) send_sample(12'($urandom_range(4095)));

    // Directed running samples: extremes and alternating bits.
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h000);
    send_sample(12'h000);
    drain();

    // Zero window acts as one; top gain and calibration give the largest scale factors.
    write_reg(arm_pkg::REG_WINDOW_LENGTH, 0);
    write_reg(arm_pkg::REG_BASELINE_GAIN, 16'hFFFF);
    write_reg(arm_pkg::REG_AMPS_PER_COUNT, 20'hFFFFF);
    for (int i = 0; i < 6; i++) send_sample(i[0] ? 12'hFFF : 12'h000);
    drain();

    // Gate at maximum forces zero; out of range index is absent (2-bit port).
    write_reg(arm_pkg::REG_NOISE_GATE, 32'hFFFF_FFFF);
    write_reg(arm_pkg::REG_BASELINE_GAIN, 0);
    write_reg(arm_pkg::REG_AMPS_PER_COUNT, 0);
    write_reg(arm_pkg::REG_WINDOW_LENGTH, 1);
    for (int i = 0; i < 3; i++) send_sample(12'($urandom_range(4095)));
    drain();

    // Random phases with changing settings and idling patterns.
    for (int p = 0; p < 6; p++) begin
      if (p == 2) begin
        send_idle = 58;
        recv_idle = 11;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_reg(arm_pkg::REG_WINDOW_LENGTH, (p == 5) ? 1023 : $urandom_range(2, 24));
      write_reg(arm_pkg::REG_BASELINE_GAIN, $urandom_range(65535));
      write_reg(arm_pkg::REG_AMPS_PER_COUNT, (p == 3) ? 20'hFFFFF : $urandom_range(1048575));
      write_reg(arm_pkg::REG_NOISE_GATE, (p == 1) ? $urandom : $urandom_range(20000));
      if (p == 4) begin
        // Hold the receiver off long enough for the queue to fill.
        fork
          begin
            hold_off = 1;
            repeat (3000) @(negedge clk);
            hold_off = 0;
          end
        join_none
      end
      phase_run((p == 5) ? 1030 : 170, $urandom_range(2047));
      drain();
    end

    if (fails == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
